// ===== rtl/core/c2mp_pkg.sv =====
// ----------------------------------------------------------------------------
// c2mp_pkg
// shared constants, arctangent table and rotation stage type for the polar converter
// ----------------------------------------------------------------------------
package c2mp_pkg;

  // width of the rotation datapath and of the angle accumulator (2^32 = one turn)
  localparam int unsigned CORDIC_W     = 64;
  localparam int unsigned ACC_W        = 32;
  localparam int unsigned CORDIC_STEPS = 31;

  // accumulator start for vectors folded from the left half plane
  localparam logic [ACC_W-1:0] ACC_HALF_TURN = 32'h8000_0000;

  // atan(2^-i) in turns scaled by 2^32
  localparam logic [ACC_W-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'h2000_0000, 32'h12E4_051D, 32'h09FB_385B, 32'h0511_11D4, 32'h028B_0D43,
    32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55, 32'h0028_BE53, 32'h0014_5F2E,
    32'h000A_2F98, 32'h0005_17CC, 32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2F9,
    32'h0000_517C, 32'h0000_28BE, 32'h0000_145F, 32'h0000_0A2F, 32'h0000_0517,
    32'h0000_028B, 32'h0000_0145, 32'h0000_00A2, 32'h0000_0051, 32'h0000_0028,
    32'h0000_0014, 32'h0000_000A, 32'h0000_0005, 32'h0000_0002, 32'h0000_0001,
    32'h0000_0000
  };

  // rotation state carried down the pipeline
  typedef struct packed {
    logic signed [CORDIC_W-1:0] x;
    logic signed [CORDIC_W-1:0] y;
    logic [ACC_W-1:0]           acc;
    logic                       zero;
  } cordic_t;

endpackage

// ===== rtl/core/c2mp_in_if.sv =====
// ----------------------------------------------------------------------------
// c2mp_in_if
// valid/ready channel carrying one complex sample
// ----------------------------------------------------------------------------
interface c2mp_in_if #(
  parameter int unsigned SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] real_part;
  logic signed [SAMPLE_BITS-1:0] imag_part;

  modport source (output valid, output real_part, output imag_part, input ready);
  modport sink (input valid, input real_part, input imag_part, output ready);
endinterface

// ===== rtl/core/c2mp_out_if.sv =====
// ----------------------------------------------------------------------------
// c2mp_out_if
// valid/ready channel carrying one magnitude and phase result
// ----------------------------------------------------------------------------
interface c2mp_out_if #(
  parameter int unsigned SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic [SAMPLE_BITS-1:0]        magnitude;
  logic signed [SAMPLE_BITS-1:0] phase_angle;

  modport source (output valid, output magnitude, output phase_angle, input ready);
  modport sink (input valid, input magnitude, input phase_angle, output ready);
endinterface

// ===== rtl/core/c2mp_prep.sv =====
// ----------------------------------------------------------------------------
// c2mp_prep
// input stage: half-plane fold, scaling into the rotation datapath, squares
// ----------------------------------------------------------------------------
module c2mp_prep #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic signed [SAMPLE_BITS-1:0]   real_part_i,
  input  logic signed [SAMPLE_BITS-1:0]   imag_part_i,
  output c2mp_pkg::cordic_t               cordic_o,
  output logic [2*SAMPLE_BITS-1:0]        sq_re_o,
  output logic [2*SAMPLE_BITS-1:0]        sq_im_o
);

  localparam int unsigned SCALE_SH = c2mp_pkg::CORDIC_W - 2 - SAMPLE_BITS;
  localparam int unsigned EXT_W    = c2mp_pkg::CORDIC_W - SAMPLE_BITS;

  logic signed [c2mp_pkg::CORDIC_W-1:0] re_ext, im_ext;
  logic signed [2*SAMPLE_BITS-1:0]      sq_re, sq_im;
  logic                                 neg;
  c2mp_pkg::cordic_t                    cordic_d, cordic_q;
  logic [2*SAMPLE_BITS-1:0]             sq_re_q, sq_im_q;

  always_comb begin
    re_ext = {{EXT_W{real_part_i[SAMPLE_BITS-1]}}, real_part_i};
    im_ext = {{EXT_W{imag_part_i[SAMPLE_BITS-1]}}, imag_part_i};
    neg    = real_part_i[SAMPLE_BITS-1];
    // left half plane: rotate by pi first
    cordic_d.x    = (neg ? -re_ext : re_ext) <<< SCALE_SH;
    cordic_d.y    = (neg ? -im_ext : im_ext) <<< SCALE_SH;
    cordic_d.acc  = neg ? c2mp_pkg::ACC_HALF_TURN : '0;
    cordic_d.zero = (real_part_i == '0) && (imag_part_i == '0);
    sq_re = real_part_i * real_part_i;
    sq_im = imag_part_i * imag_part_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cordic_q <= cordic_d;
      sq_re_q  <= unsigned'(sq_re);
      sq_im_q  <= unsigned'(sq_im);
    end
  end

  assign cordic_o = cordic_q;
  assign sq_re_o  = sq_re_q;
  assign sq_im_o  = sq_im_q;

endmodule

// ===== rtl/core/c2mp_cordic_stage.sv =====
// ----------------------------------------------------------------------------
// c2mp_cordic_stage
// one registered vectoring micro-rotation; plain delay past the last step
// ----------------------------------------------------------------------------
module c2mp_cordic_stage #(
  parameter int unsigned STEP = 0
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  c2mp_pkg::cordic_t cordic_i,
  output c2mp_pkg::cordic_t cordic_o
);

  c2mp_pkg::cordic_t cordic_d, cordic_q;

  if (STEP < c2mp_pkg::CORDIC_STEPS) begin : g_rot
    localparam logic [c2mp_pkg::ACC_W-1:0] ANGLE = c2mp_pkg::ATAN_TURNS[STEP];

    logic signed [c2mp_pkg::CORDIC_W-1:0] x_in, y_in, dx, dy;

    always_comb begin
      x_in = cordic_i.x;
      y_in = cordic_i.y;
      // arithmetic shifts round towards minus infinity
      dx   = y_in >>> STEP;
      dy   = x_in >>> STEP;
      cordic_d.zero = cordic_i.zero;
      if (y_in[c2mp_pkg::CORDIC_W-1]) begin
        cordic_d.x   = x_in - dx;
        cordic_d.y   = y_in + dy;
        cordic_d.acc = cordic_i.acc - ANGLE;
      end else begin
        cordic_d.x   = x_in + dx;
        cordic_d.y   = y_in - dy;
        cordic_d.acc = cordic_i.acc + ANGLE;
      end
    end
  end else begin : g_delay
    assign cordic_d = cordic_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cordic_q <= cordic_d;
    end
  end

  assign cordic_o = cordic_q;

endmodule

// ===== rtl/core/c2mp_sqrt_stage.sv =====
// ----------------------------------------------------------------------------
// c2mp_sqrt_stage
// one registered digit, or a plain delay past the last digit, of the restoring integer square root
// ----------------------------------------------------------------------------
module c2mp_sqrt_stage #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned STEP        = 0
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [2*SAMPLE_BITS-1:0]   rad_i,
  input  logic [SAMPLE_BITS:0]       rem_i,
  input  logic [SAMPLE_BITS-1:0]     root_i,
  output logic [2*SAMPLE_BITS-1:0]   rad_o,
  output logic [SAMPLE_BITS:0]       rem_o,
  output logic [SAMPLE_BITS-1:0]     root_o
);

  localparam int unsigned RAD_W = 2 * SAMPLE_BITS;
  localparam int unsigned CUR_W = SAMPLE_BITS + 3;

  logic [RAD_W-1:0]       rad_d, rad_q;
  logic [SAMPLE_BITS:0]   rem_d, rem_q;
  logic [SAMPLE_BITS-1:0] root_d, root_q;

  if (STEP < SAMPLE_BITS) begin : g_digit
    logic [CUR_W-1:0] cur, trial, diff;
    logic             fits;

    always_comb begin
      // bring down the next two radicand bits
      cur   = {rem_i, rad_i[RAD_W-1 -: 2]};
      trial = {1'b0, root_i, 2'b01};
      diff  = cur - trial;
      fits  = (cur >= trial);
      rad_d = rad_i << 2;
      // remainder never exceeds twice the partial root
      rem_d  = fits ? diff[SAMPLE_BITS:0] : cur[SAMPLE_BITS:0];
      root_d = {root_i[SAMPLE_BITS-2:0], fits};
    end
  end else begin : g_delay
    always_comb begin
      rad_d  = rad_i;
      rem_d  = rem_i;
      root_d = root_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q  <= rad_d;
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign rad_o  = rad_q;
  assign rem_o  = rem_q;
  assign root_o = root_q;

endmodule

// ===== rtl/core/c2mp_round.sv =====
// ----------------------------------------------------------------------------
// c2mp_round
// output register: rounds root and accumulated angle to sample width
// ----------------------------------------------------------------------------
module c2mp_round #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  c2mp_pkg::cordic_t             cordic_i,
  input  logic [SAMPLE_BITS:0]          rem_i,
  input  logic [SAMPLE_BITS-1:0]        root_i,
  output logic [SAMPLE_BITS-1:0]        magnitude_o,
  output logic signed [SAMPLE_BITS-1:0] phase_angle_o
);

  localparam int unsigned DROP = c2mp_pkg::ACC_W - SAMPLE_BITS;

  logic [SAMPLE_BITS:0]          mag_sum;
  logic [SAMPLE_BITS-1:0]        mag_d, mag_q;
  logic [SAMPLE_BITS-1:0]        ph_rnd;
  logic signed [SAMPLE_BITS-1:0] ph_d, ph_q;

  if (DROP == 0) begin : g_full
    assign ph_rnd = cordic_i.acc[SAMPLE_BITS-1:0];
  end else begin : g_drop
    localparam logic [c2mp_pkg::ACC_W-1:0] HALF_LSB = c2mp_pkg::ACC_W'(1) << (DROP - 1);
    logic [c2mp_pkg::ACC_W-1:0] acc_rnd;
    // round half up, wrap at a full turn
    assign acc_rnd = cordic_i.acc + HALF_LSB;
    assign ph_rnd  = acc_rnd[c2mp_pkg::ACC_W-1:DROP];
  end

  always_comb begin
    // round to nearest: remainder above root means past the half
    mag_sum = {1'b0, root_i} + {{SAMPLE_BITS{1'b0}}, (rem_i > {1'b0, root_i})};
    mag_d   = mag_sum[SAMPLE_BITS-1:0];
    ph_d    = cordic_i.zero ? '0 : signed'(ph_rnd);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q <= mag_d;
      ph_q  <= ph_d;
    end
  end

  assign magnitude_o   = mag_q;
  assign phase_angle_o = ph_q;

endmodule

// ===== rtl/core/complex_to_magnitude_phase_top.sv =====
// ----------------------------------------------------------------------------
// complex_to_magnitude_phase_top
// rectangular to polar converter: rounded magnitude and binary-angle phase
// ----------------------------------------------------------------------------
// pipeline: input rank, NUM_STAGES stage ranks, then the output rank, where
//   NUM_STAGES = max(31, SAMPLE_BITS + 1)
// throughput: one item per cycle while no result is held, set by the fully unrolled rotation pipeline
// a result held at the output freezes every stage until it is taken
// reset clears only the stage valid bits; the datapath registers are not reset
// ----------------------------------------------------------------------------
module complex_to_magnitude_phase_top #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  c2mp_in_if.sink           sample_i,
  c2mp_out_if.source        result_o
);

  // the rotation needs 31 stages, the root one sum stage plus one per digit
  localparam int unsigned NUM_STAGES =
      (c2mp_pkg::CORDIC_STEPS > SAMPLE_BITS + 1) ? c2mp_pkg::CORDIC_STEPS
                                                 : SAMPLE_BITS + 1;
  localparam int unsigned RAD_W = 2 * SAMPLE_BITS;

  // pipeline advance: the whole pipe moves unless the output item is stuck
  logic adv;

  // valid bit per register rank: 0 = input stage, NUM_STAGES + 1 = output
  logic [NUM_STAGES+1:0] vld_q;

  // rotation path
  c2mp_pkg::cordic_t cordic_w [NUM_STAGES+1];

  // magnitude path
  logic [RAD_W-1:0]       sq_re, sq_im;
  logic [RAD_W-1:0]       rad1_q;
  logic [RAD_W-1:0]       rad_w  [1:NUM_STAGES];
  logic [SAMPLE_BITS:0]   rem_w  [1:NUM_STAGES];
  logic [SAMPLE_BITS-1:0] root_w [1:NUM_STAGES];

  assign adv            = !vld_q[NUM_STAGES+1] || result_o.ready;
  assign sample_i.ready = adv;
  assign result_o.valid = vld_q[NUM_STAGES+1];

  // valid bits move in lock step with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NUM_STAGES:0], sample_i.valid};
    end
  end

  // input rank: fold into the right half plane, scale up, square both parts
  c2mp_prep #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_prep (
    .clk_i       (clk_i),
    .en_i        (adv),
    .real_part_i (sample_i.real_part),
    .imag_part_i (sample_i.imag_part),
    .cordic_o    (cordic_w[0]),
    .sq_re_o     (sq_re),
    .sq_im_o     (sq_im)
  );

  // first rank of the magnitude path: sum of squares, root starts empty
  always_ff @(posedge clk_i) begin
    if (adv) begin
      rad1_q <= sq_re + sq_im;
    end
  end

  assign rad_w[1]  = rad1_q;
  assign rem_w[1]  = '0;
  assign root_w[1] = '0;

  // rank k: rotation step k-1 alongside root digit k-2
  for (genvar k = 1; k <= NUM_STAGES; k++) begin : g_stage
    c2mp_cordic_stage #(
      .STEP (k - 1)
    ) u_cordic (
      .clk_i    (clk_i),
      .en_i     (adv),
      .cordic_i (cordic_w[k-1]),
      .cordic_o (cordic_w[k])
    );

    if (k >= 2) begin : g_root
      c2mp_sqrt_stage #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .STEP        (k - 2)
      ) u_sqrt (
        .clk_i  (clk_i),
        .en_i   (adv),
        .rad_i  (rad_w[k-1]),
        .rem_i  (rem_w[k-1]),
        .root_i (root_w[k-1]),
        .rad_o  (rad_w[k]),
        .rem_o  (rem_w[k]),
        .root_o (root_w[k])
      );
    end
  end

  // output rank: rounding of both results, doubles as the output register
  c2mp_round #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_round (
    .clk_i         (clk_i),
    .en_i          (adv),
    .cordic_i      (cordic_w[NUM_STAGES]),
    .rem_i         (rem_w[NUM_STAGES]),
    .root_i        (root_w[NUM_STAGES]),
    .magnitude_o   (result_o.magnitude),
    .phase_angle_o (result_o.phase_angle)
  );

endmodule

// ===== rtl/core/c2mp_checker.sv =====
// ----------------------------------------------------------------------------
// c2mp_checker
// port-level checks on the polar converter, bound to the top level
// ----------------------------------------------------------------------------
module c2mp_checker #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [SAMPLE_BITS-1:0]        magnitude_i,
  input logic signed [SAMPLE_BITS-1:0] phase_angle_i
);

  // a stalled result item stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(magnitude_i)
                                    && $stable(phase_angle_i))
    else $error("result item changed while stalled");

  // the pipe only stalls on a held result
  a_ready_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_i)
    else $error("input stalled while output was taken");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input stalled without a pending result item");

  // any nonzero sample has length of at least one
  a_zero_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (magnitude_i == '0) |-> (phase_angle_i == '0))
    else $error("zero magnitude with nonzero phase");

  a_reset_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_i)
    else $error("result item present straight after reset");

endmodule

bind complex_to_magnitude_phase_top c2mp_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_c2mp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_i    (sample_i.ready),
  .out_valid_i   (result_o.valid),
  .out_ready_i   (result_o.ready),
  .magnitude_i   (result_o.magnitude),
  .phase_angle_i (result_o.phase_angle)
);

// ===== tb/sv/tb_complex_to_magnitude_phase_top.sv =====
// ----------------------------------------------------------------------------
// tb_complex_to_magnitude_phase_top
// self-checking bench for the rectangular to polar converter: a directed
// table of axis, diagonal and extreme samples, then random samples under
// three idling mixes; typed-in rows are checked against their own result, the rest against an in-bench
// bit-exact model of the rounded magnitude and the vectoring phase
// ----------------------------------------------------------------------------
module tb_complex_to_magnitude_phase_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned TURN_BITS   = 32;
  localparam int unsigned ROTATIONS   = 31;
  localparam int unsigned LATENCY     = 33;
  localparam int unsigned N_DIRECTED  = 22;
  localparam int unsigned N_PER_MIX   = 433;
  localparam int unsigned MAX_REPORTS = 10;

  // atan(2^-i) in 2^-32 turns, kept apart from the design's own table
  localparam logic [TURN_BITS-1:0] ARCTAN_STEP [ROTATIONS] = '{
    32'h2000_0000, 32'h12E4_051D, 32'h09FB_385B, 32'h0511_11D4, 32'h028B_0D43,
    32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55, 32'h0028_BE53, 32'h0014_5F2E,
    32'h000A_2F98, 32'h0005_17CC, 32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2F9,
    32'h0000_517C, 32'h0000_28BE, 32'h0000_145F, 32'h0000_0A2F, 32'h0000_0517,
    32'h0000_028B, 32'h0000_0145, 32'h0000_00A2, 32'h0000_0051, 32'h0000_0028,
    32'h0000_0014, 32'h0000_000A, 32'h0000_0005, 32'h0000_0002, 32'h0000_0001,
    32'h0000_0000
  };
  localparam logic [TURN_BITS-1:0] HALF_TURN = 32'h8000_0000;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0]        magnitude;
    logic signed [SAMPLE_BITS-1:0] phase_angle;
  } polar_t;

  // one row of the directed table; known rows carry their result typed in
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] re;
    logic signed [SAMPLE_BITS-1:0] im;
    logic                          known;
    logic [SAMPLE_BITS-1:0]        magnitude;
    logic signed [SAMPLE_BITS-1:0] phase_angle;
  } sample_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  c2mp_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) sample_if ();
  c2mp_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) result_if ();

  complex_to_magnitude_phase_top #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_if),
    .result_o (result_if)
  );

  // polar results still owed by the pipeline, oldest first
  polar_t      pending_polar [$];
  int unsigned mismatch_count = 0;
  // idling mix, in percent of cycles
  int unsigned sender_idle_pct   = 0;
  int unsigned receiver_stall_pct = 0;
  sample_row_t directed_rows [N_DIRECTED];

  always #2 clk_i = ~clk_i;

  // rounded magnitude by exact integer square root, phase by the same
  // 31-step vectoring rotation on a 64-bit datapath with a 32-bit turn count
  function automatic polar_t polar_of(input logic signed [SAMPLE_BITS-1:0] re_in,
                                     input logic signed [SAMPLE_BITS-1:0] im_in);
    polar_t               res;
    longint               re;
    longint               im;
    longint               x;
    longint               y;
    longint               dx;
    longint               dy;
    longint unsigned      energy;
    longint unsigned      rem;
    longint unsigned      root;
    longint unsigned      probe;
    logic [TURN_BITS-1:0] turns;
    logic [TURN_BITS:0]   rounded;
    int                   step;
    re     = re_in;
    im     = im_in;
    energy = longint'(re * re + im * im);
    rem    = energy;
    root   = 0;
    probe  = 64'd1 << 62;
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem  = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    // round to nearest, a tie cannot arise for integer squares
    if (energy - root * root > root) root = root + 1;
    res.magnitude = root[SAMPLE_BITS-1:0];

    if (re == 0 && im == 0) begin
      res.phase_angle = '0;
    end else begin
      turns = '0;
      // fold the left half plane onto the right, half a turn to add back
      if (re < 0) begin
        re    = -re;
        im    = -im;
        turns = HALF_TURN;
      end
      x = re <<< (62 - SAMPLE_BITS);
      y = im <<< (62 - SAMPLE_BITS);
      for (step = 0; step < ROTATIONS; step++) begin
        dx = y >>> step;
        dy = x >>> step;
        if (y >= 0) begin
          x     = x + dx;
          y     = y - dy;
          turns = turns + ARCTAN_STEP[step];
        end else begin
          x     = x - dx;
          y     = y + dy;
          turns = turns - ARCTAN_STEP[step];
        end
      end
      // round half up to the sample width, wrapping at a full turn
      rounded = {1'b0, turns} + (33'd1 << (TURN_BITS - SAMPLE_BITS - 1));
      res.phase_angle = rounded[TURN_BITS-1 -: SAMPLE_BITS];
    end
    return res;
  endfunction

  task automatic note_failure(input string what, input polar_t want, input polar_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%0t: %s: expected mag %0d phase %0d, got mag %0d phase %0d",
               $realtime, what, want.magnitude, want.phase_angle,
               got.magnitude, got.phase_angle);
  endtask

  // offer one sample, with a random idle gap ahead of it; valid is left high
  // after acceptance so that back-to-back samples see no idle cycle between them
  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] re,
                             input logic signed [SAMPLE_BITS-1:0] im,
                             input logic                          known,
                             input polar_t                        typed);
    polar_t want;
    want = known ? typed : polar_of(re, im);
    if ($urandom_range(99) < sender_idle_pct) begin
      sample_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < sender_idle_pct);
    end
    sample_if.valid     <= 1'b1;
    sample_if.real_part <= re;
    sample_if.imag_part <= im;
    @(posedge clk_i);
    while (!sample_if.ready) @(posedge clk_i);
    pending_polar.push_back(want);
  endtask

  // hold the sender back until the pipeline has handed over everything
  task automatic drain_pipeline();
    sample_if.valid <= 1'b0;
    while (pending_polar.size() != 0) @(posedge clk_i);
  endtask

  // receiver: ready redrawn every cycle from the current stall mix
  initial begin
    result_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      result_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // result checker: sampled at the edge, before any design update lands
  always @(posedge clk_i) begin
    polar_t got;
    polar_t want;
    if (rst_ni && result_if.valid && result_if.ready) begin
      got.magnitude   = result_if.magnitude;
      got.phase_angle = result_if.phase_angle;
      if (pending_polar.size() == 0) begin
        note_failure("result item with none outstanding", '0, got);
      end else begin
        want = pending_polar.pop_front();
        if (got.magnitude !== want.magnitude || got.phase_angle !== want.phase_angle)
          note_failure("result item mismatch", want, got);
      end
    end
  end

  // stimulus
  initial begin
    logic signed [SAMPLE_BITS-1:0] re;
    logic signed [SAMPLE_BITS-1:0] im;
    logic signed [SAMPLE_BITS-1:0] base;
    int unsigned                   mix;
    int unsigned                   n;
    polar_t                        typed;

    sample_if.valid     = 1'b0;
    sample_if.real_part = '0;
    sample_if.imag_part = '0;

    //                  re       im      known  mag    phase
    directed_rows = '{
      '{ 16'sd0,      16'sd0,     1'b1, 16'd0,     16'sd0     },  // zero input
      '{ 16'sd32767,  16'sd0,     1'b1, 16'd32767, 16'sd0     },
      '{ -16'sd32767 - 16'sd1, 16'sd0, 1'b1, 16'd32768, 16'sh8000 }, // negative real axis
      '{ 16'sd0,      16'sd32767, 1'b1, 16'd32767, 16'sd16384 },
      '{ 16'sd0, -16'sd32767 - 16'sd1, 1'b1, 16'd32768, -16'sd16384 },
      '{ -16'sd32767 - 16'sd1, -16'sd32767 - 16'sd1, 1'b1, 16'd46341, -16'sd24576 },
      '{ -16'sd1,     16'sd0,     1'b1, 16'd1,     16'sh8000  },  // smallest on negative axis
      '{ 16'sd1,      16'sd0,     1'b1, 16'd1,     16'sd0     },
      '{ 16'sd0,      16'sd1,     1'b1, 16'd1,     16'sd16384 },
      '{ 16'sd0,      -16'sd1,    1'b1, 16'd1,     -16'sd16384 },
      '{ 16'sd32767,  16'sd32767, 1'b0, 16'd0,     16'sd0     },
      '{ -16'sd32767 - 16'sd1, 16'sd32767, 1'b0, 16'd0, 16'sd0 },
      '{ 16'sd32767, -16'sd32767 - 16'sd1, 1'b0, 16'd0, 16'sd0 },
      '{ -16'sd1,     -16'sd1,    1'b0, 16'd0,     16'sd0     },
      '{ 16'sd1,      16'sd1,     1'b0, 16'd0,     16'sd0     },
      // just either side of the negative axis, where the phase wraps
      '{ -16'sd32767 - 16'sd1, 16'sd1,  1'b0, 16'd0, 16'sd0    },
      '{ -16'sd32767 - 16'sd1, -16'sd1, 1'b0, 16'd0, 16'sd0    },
      '{ 16'sd32767,  -16'sd1,    1'b0, 16'd0,     16'sd0     },
      '{ -16'sd1,     16'sd32767, 1'b0, 16'd0,     16'sd0     },
      '{ 16'sd12345,  -16'sd23456, 1'b0, 16'd0,    16'sd0     },
      '{ 16'sd3,      16'sd4,     1'b0, 16'd0,     16'sd0     },
      '{ -16'sd5,     16'sd12,    1'b0, 16'd0,     16'sd0     }
    };

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (mix = 0; mix < 3; mix++) begin
      // sender idles lightly against a stalling receiver, then the reverse,
      // then both run flat out
      case (mix)
        0: begin
          sender_idle_pct    = 8;
          receiver_stall_pct = 67;
        end
        1: begin
          sender_idle_pct    = 67;
          receiver_stall_pct = 8;
        end
        default: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 0;
        end
      endcase

      if (mix == 0) begin
        for (n = 0; n < N_DIRECTED; n++) begin
          typed.magnitude   = directed_rows[n].magnitude;
          typed.phase_angle = directed_rows[n].phase_angle;
          send_sample(directed_rows[n].re, directed_rows[n].im,
                      directed_rows[n].known, typed);
        end
      end

      for (n = 0; n < N_PER_MIX; n++) begin
        case ($urandom_range(3))
          0: begin
            // anywhere in the plane
            re = SAMPLE_BITS'($urandom());
            im = SAMPLE_BITS'($urandom());
          end
          1: begin
            // short vectors, where truncation in the rotation matters most
            re = SAMPLE_BITS'($urandom_range(32)) - 16'sd16;
            im = SAMPLE_BITS'($urandom_range(32)) - 16'sd16;
          end
          2: begin
            // close to an axis, either way round
            re = SAMPLE_BITS'($urandom());
            im = SAMPLE_BITS'($urandom_range(8)) - 16'sd4;
            if ($urandom_range(1)) begin
              base = re;
              re   = im;
              im   = base;
            end
          end
          default: begin
            // close to a diagonal, any quadrant
            base = SAMPLE_BITS'($urandom());
            re   = base;
            im   = $urandom_range(1) ? base : -base;
            im   = im + (SAMPLE_BITS'($urandom_range(2)) - 16'sd1);
          end
        endcase
        send_sample(re, im, 1'b0, '0);
      end

      drain_pipeline();
    end

    // nothing owed any more; let the pipeline run empty before the verdict
    repeat (LATENCY + 8) @(posedge clk_i);
    if (mismatch_count == 0 && pending_polar.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #1000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
